>>> design/hpd_pkg.sv
// Shared types, constants and the threshold table for the core hotplug decision block.
// No dependencies; every other design file imports this package.
package hpd_pkg;

    localparam int NUM_CORES_DEF = 4;
    localparam int LOAD_W        = 7;
    localparam int N_W           = 3;
    localparam int NOW_W         = 48;
    localparam int DL_W          = 49;
    localparam int SUM_W         = 9;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    // floor(x / 3) as (x * 171) >> 9, exact for x below 512
    localparam logic [7:0] RECIP3    = 8'd171;
    localparam int         RECIP3_SH = 9;

    localparam logic [2:0]  RST_TOUCH_CORES = 3'd2;
    localparam logic [15:0] RST_HOLD_MS     = 16'd3000;
    localparam logic [6:0]  RST_TARGET      = 7'd50;

    localparam logic signed [7:0] UP_IDLE  = 8'sd3;
    localparam logic signed [7:0] DN_IDLE  = 8'sd6;
    localparam logic signed [7:0] UP_TOUCH = 8'sd15;
    localparam logic signed [7:0] DN_TOUCH = 8'sd7;
    localparam logic signed [7:0] UP_NORM  = 8'sd10;
    localparam logic signed [7:0] DN_NORM  = 8'sd5;

    localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_CORES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET      = 2'd2;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_UP   = 2'd1,
        ACT_DOWN = 2'd2
    } t_action;

    typedef struct packed {
        logic [2:0]  touch_cores;
        logic [15:0] hold_ms;
        logic [6:0]  target;
    } t_cfg;

    typedef struct packed {
        logic [NOW_W-1:0] now;
        logic [N_W-1:0]   n;
        logic             gpu_quiet;
        logic             touch;
    } t_item;

    typedef struct packed {
        logic [LOAD_W-1:0] dn;
        logic [LOAD_W-1:0] up;
    } t_level;

    // thresholds by GPU state and online core count minus one
    function automatic t_level hpd_level(input logic gpu_busy, input logic [1:0] idx);
        t_level l;
        l = '{dn: 7'd0, up: 7'd0};
        if (!gpu_busy) begin
            case (idx)
                2'd0: l = '{dn: 7'd0,  up: 7'd80};
                2'd1: l = '{dn: 7'd40, up: 7'd85};
                2'd2: l = '{dn: 7'd50, up: 7'd90};
                default: l = '{dn: 7'd60, up: 7'd100};
            endcase
        end else begin
            case (idx)
                2'd0: l = '{dn: 7'd0,  up: 7'd60};
                2'd1: l = '{dn: 7'd30, up: 7'd60};
                2'd2: l = '{dn: 7'd30, up: 7'd65};
                default: l = '{dn: 7'd40, up: 7'd100};
            endcase
        end
        return l;
    endfunction

endpackage

>>> design/hpd_lane.sv
// One load lane: captures a core's load, zeroed when the core is offline.
// Depends on hpd_pkg.
module hpd_lane
    import hpd_pkg::*;
#(
    parameter int LANE = 0
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [LOAD_W-1:0] i_load,
    input  logic [N_W-1:0]    i_n,
    output logic [LOAD_W-1:0] o_load
);

    localparam logic [N_W-1:0] LANE_ID = N_W'(LANE);

    logic [LOAD_W-1:0] r_load;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_load <= (LANE_ID < i_n) ? i_load : '0;
        end
    end

    assign o_load = r_load;

endmodule

>>> design/hpd_merge.sv
// Merge stage: sums the lane loads and divides by the online core count.
// Depends on hpd_pkg; fed by the hpd_lane outputs.
module hpd_merge
    import hpd_pkg::*;
#(
    parameter int NUM_CORES = NUM_CORES_DEF
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [LOAD_W-1:0] i_loads [NUM_CORES],
    input  logic [N_W-1:0]    i_n,
    output logic [LOAD_W-1:0] o_avg
);

    logic [SUM_W-1:0]   sum;
    logic [SUM_W+7:0]   prod3;
    logic [LOAD_W-1:0]  avg;
    logic [LOAD_W-1:0]  r_avg;

    always_comb begin
        sum = '0;
        for (int i = 0; i < NUM_CORES; i++) begin
            sum = sum + SUM_W'(i_loads[i]);
        end
        prod3 = (SUM_W+8)'(sum) * (SUM_W+8)'(RECIP3);
        unique case (i_n)
            3'd2:    avg = LOAD_W'(sum >> 1);
            3'd3:    avg = LOAD_W'(prod3 >> RECIP3_SH);
            3'd4:    avg = LOAD_W'(sum >> 2);
            default: avg = LOAD_W'(sum);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_avg <= avg;
        end
    end

    assign o_avg = r_avg;

endmodule

>>> design/hpd_ctrl.sv
// Decision logic: up/down counters, hold deadline and the core change request.
// Depends on hpd_pkg; takes the average from hpd_merge.
module hpd_ctrl
    import hpd_pkg::*;
#(
    parameter int NUM_CORES = NUM_CORES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_item             i_s1,
    input  logic              i_s1_adv,
    input  t_item             i_s2,
    input  logic              i_dec,
    input  logic [LOAD_W-1:0] i_avg,
    output t_action           o_action,
    output logic [1:0]        o_core
);

    localparam logic [N_W-1:0] NUM_N = N_W'(NUM_CORES);

    logic signed [7:0] r_up, n_up, r_dn, n_dn;
    logic [DL_W-1:0]   r_dl, n_dl;
    logic [DL_W-1:0]   r_dl_full, r_dl_half;
    logic signed [7:0] tgt, upv, dnv, u1, d1;
    logic [DL_W-1:0]   now49;
    t_level            lvl;

    function automatic logic signed [7:0] sat8(input logic signed [9:0] v);
        if (v > 10'sd127) return 8'sd127;
        if (v < -10'sd128) return -8'sd128;
        return v[7:0];
    endfunction

    function automatic logic signed [9:0] ext(input logic signed [7:0] v);
        return {{2{v[7]}}, v};
    endfunction

    // deadline candidates one stage ahead of the decision
    always_ff @(posedge i_clk) begin
        if (i_s1_adv) begin
            r_dl_full <= DL_W'(i_s1.now) + DL_W'(i_cfg.hold_ms);
            r_dl_half <= DL_W'(i_s1.now) + DL_W'(i_cfg.hold_ms >> 1);
        end
    end

    always_comb begin
        tgt   = signed'({1'b0, i_cfg.target});
        now49 = DL_W'(i_s2.now);
        lvl   = hpd_level(!i_s2.gpu_quiet, 2'(i_s2.n - 3'd1));
        if (i_s2.gpu_quiet) begin
            upv = UP_IDLE;
            dnv = DN_IDLE;
        end else if (i_s2.touch && (i_s2.n < i_cfg.touch_cores)) begin
            upv = UP_TOUCH;
            dnv = DN_TOUCH;
        end else begin
            upv = UP_NORM;
            dnv = DN_NORM;
        end
        n_up     = r_up;
        n_dn     = r_dn;
        n_dl     = r_dl;
        u1       = r_up;
        d1       = r_dn;
        o_action = ACT_NONE;
        o_core   = '0;
        if (i_avg >= lvl.up) begin
            n_dl = r_dl_full;
            if (r_up < tgt) u1 = sat8(ext(r_up) + ext(upv));
            if (r_dn > 8'sd0) d1 = sat8(ext(r_dn) - ext(upv));
            if ((u1 >= tgt) && (i_s2.n < NUM_N)) begin
                o_action = ACT_UP;
                o_core   = 2'(i_s2.n);
                n_up     = '0;
                n_dn     = -tgt;
            end else begin
                n_up = u1;
                n_dn = d1;
            end
        end else if (i_avg <= lvl.dn) begin
            if (r_dn < tgt) d1 = sat8(ext(r_dn) + ext(dnv));
            if (r_up > 8'sd0) u1 = sat8(ext(r_up) - ext(dnv));
            // block at one core, or at the touch count while the hold lasts
            if ((d1 >= tgt) && !((i_s2.n == 3'd1) ||
                ((i_s2.n == i_cfg.touch_cores) && (r_dl > now49)))) begin
                o_action = ACT_DOWN;
                o_core   = 2'(i_s2.n - 3'd1);
                n_dl     = r_dl_full;
                n_up     = '0;
                n_dn     = '0;
            end else begin
                n_up = u1;
                n_dn = d1;
            end
        end else begin
            if (r_dl_half > r_dl) n_dl = r_dl_half;
            if (r_up > 8'sd0) n_up = sat8(ext(r_up) - ext(dnv));
            if (r_dn > 8'sd0) n_dn = sat8(ext(r_dn) - ext(dnv));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up <= '0;
            r_dn <= '0;
            r_dl <= '0;
        end else if (i_dec) begin
            r_up <= n_up;
            r_dn <= n_dn;
            r_dl <= n_dl;
        end
    end

endmodule

>>> design/core_hotplug_decision.sv
// Core hotplug decision, top level.
// An accepted request passes the capture, average and decision stages into the output register.
// A new request is taken only once the last has left the decision stage; these stages hold
// a single request, since the counters it updates feed the next decision.
// The output register can hold a finished result while the next request is taken.
// Reset (synchronous, active low) clears counters, deadline and valids, and loads the config registers.
module core_hotplug_decision
    import hpd_pkg::*;
#(
    parameter int NUM_CORES = NUM_CORES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [NOW_W-1:0]      i_now_ms,
    input  logic [LOAD_W-1:0]     i_load_core0,
    input  logic [LOAD_W-1:0]     i_load_core1,
    input  logic [LOAD_W-1:0]     i_load_core2,
    input  logic [LOAD_W-1:0]     i_load_core3,
    input  logic [N_W-1:0]        i_cores_online,
    input  logic                  i_gpu_is_idle,
    input  logic                  i_touch_boost_active,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_action,
    output logic [1:0]            o_target_core,
    output logic [LOAD_W-1:0]     o_average_load
);

    localparam logic [N_W-1:0] NUM_N = N_W'(NUM_CORES);

    t_cfg              r_cfg;
    t_item             r_s1, r_s2;
    logic              r_s1_v, r_s2_v, r_out_v;
    logic [1:0]        r_out_action, r_out_core;
    logic [LOAD_W-1:0] r_out_avg;
    logic              in_accept, dec;
    logic [N_W-1:0]    n_clamp;
    logic [LOAD_W-1:0] loads_in [4];
    logic [LOAD_W-1:0] lane_load [NUM_CORES];
    logic [LOAD_W-1:0] avg;
    t_action           action;
    logic [1:0]        core;

    assign o_in_stall = r_s1_v | r_s2_v;
    assign in_accept  = i_in_valid & ~o_in_stall;
    assign dec        = r_s2_v & (~r_out_v | ~i_out_stall);

    assign loads_in[0] = i_load_core0;
    assign loads_in[1] = i_load_core1;
    assign loads_in[2] = i_load_core2;
    assign loads_in[3] = i_load_core3;

    always_comb begin
        if (i_cores_online == 3'd0) begin
            n_clamp = 3'd1;
        end else if (i_cores_online > NUM_N) begin
            n_clamp = NUM_N;
        end else begin
            n_clamp = i_cores_online;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{touch_cores: RST_TOUCH_CORES, hold_ms: RST_HOLD_MS,
                       target: RST_TARGET};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TOUCH_CORES: r_cfg.touch_cores <= i_cfg_data[2:0];
                CFG_HOLD_MS:     r_cfg.hold_ms     <= i_cfg_data;
                CFG_TARGET:      r_cfg.target      <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_s1_v <= in_accept;
            if (r_s1_v) begin
                r_s2_v <= 1'b1;
            end else if (dec) begin
                r_s2_v <= 1'b0;
            end
            if (dec) begin
                r_out_v <= 1'b1;
            end else if (~i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= '{now: i_now_ms, n: n_clamp, gpu_quiet: i_gpu_is_idle,
                      touch: i_touch_boost_active};
        end
        if (r_s1_v) begin
            r_s2 <= r_s1;
        end
        if (dec) begin
            r_out_action <= action;
            r_out_core   <= core;
            r_out_avg    <= avg;
        end
    end

    for (genvar g = 0; g < NUM_CORES; g++) begin : g_lane
        hpd_lane #(
            .LANE (g)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (in_accept),
            .i_load (loads_in[g]),
            .i_n    (n_clamp),
            .o_load (lane_load[g])
        );
    end

    hpd_merge #(
        .NUM_CORES (NUM_CORES)
    ) u_merge (
        .i_clk   (i_clk),
        .i_en    (r_s1_v),
        .i_loads (lane_load),
        .i_n     (r_s1.n),
        .o_avg   (avg)
    );

    hpd_ctrl #(
        .NUM_CORES (NUM_CORES)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_s1     (r_s1),
        .i_s1_adv (r_s1_v),
        .i_s2     (r_s2),
        .i_dec    (dec),
        .i_avg    (avg),
        .o_action (action),
        .o_core   (core)
    );

    assign o_out_valid    = r_out_v;
    assign o_action       = r_out_action;
    assign o_target_core  = r_out_core;
    assign o_average_load = r_out_avg;

endmodule

>>> design/hpd_checker.sv
// Port-level checks for core_hotplug_decision, attached by the bind below.
// Depends on hpd_pkg and the top-level port list.
module hpd_checker
    import hpd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [1:0]        o_action,
    input logic [1:0]        o_target_core,
    input logic [LOAD_W-1:0] o_average_load
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_action) &&
        $stable(o_target_core) && $stable(o_average_load))
        else $error("stalled result changed");

    // one request in flight: stall right after an accepted request
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request accepted while another is in flight");

    a_no_action_core: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_action == ACT_NONE) |-> (o_target_core == 2'd0))
        else $error("target core set without an action");

    a_up_core: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_action == ACT_UP) |-> (o_target_core != 2'd0))
        else $error("bring-up targets core zero");

    a_avg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_action != 2'd3) && (o_average_load <= 7'd127))
        else $error("result out of range");

endmodule

bind core_hotplug_decision hpd_checker u_hpd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_action       (o_action),
    .o_target_core  (o_target_core),
    .o_average_load (o_average_load)
);

>>> tb/hpd_decision_checker.sv
`timescale 1ns / 100ps
// Scoreboard for core_hotplug_decision: shadows the registers, predicts every decision
// from the accepted request and its own counters, and checks results in order.
// Depends on hpd_pkg.
module hpd_decision_checker
    import hpd_pkg::*;
#(
    parameter int NUM_CORES = NUM_CORES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_req_valid,
    input  logic                  i_req_stall,
    input  logic [NOW_W-1:0]      i_now_ms,
    input  logic [LOAD_W-1:0]     i_load_core0,
    input  logic [LOAD_W-1:0]     i_load_core1,
    input  logic [LOAD_W-1:0]     i_load_core2,
    input  logic [LOAD_W-1:0]     i_load_core3,
    input  logic [N_W-1:0]        i_cores_online,
    input  logic                  i_gpu_is_idle,
    input  logic                  i_touch_boost_active,
    input  logic                  i_res_valid,
    input  logic                  i_res_stall,
    input  logic [1:0]            i_action,
    input  logic [1:0]            i_target_core,
    input  logic [LOAD_W-1:0]     i_average_load,
    output int                    o_errors,
    output int                    o_pending
);

    typedef struct packed {
        logic [NOW_W-1:0]             now;
        logic [3:0][LOAD_W-1:0]       load;
        logic [N_W-1:0]               n;
        logic                         gpu_quiet;
        logic                         touch;
    } t_tick;

    typedef struct packed {
        t_action           action;
        logic [1:0]        core;
        logic [LOAD_W-1:0] avg;
    } t_decision;

    localparam logic [63:0] DEADLINE_MASK = (64'd1 << DL_W) - 64'd1;

    // thresholds indexed by online core count minus one
    localparam logic [3:0][LOAD_W-1:0] IDLE_UP = {7'd100, 7'd90, 7'd85, 7'd80};
    localparam logic [3:0][LOAD_W-1:0] IDLE_DN = {7'd60, 7'd50, 7'd40, 7'd0};
    localparam logic [3:0][LOAD_W-1:0] BUSY_UP = {7'd100, 7'd65, 7'd60, 7'd60};
    localparam logic [3:0][LOAD_W-1:0] BUSY_DN = {7'd40, 7'd30, 7'd30, 7'd0};

    logic [2:0]  touch_cores;
    logic [15:0] hold_ms;
    logic [6:0]  count_target;
    int          up_cnt;
    int          dn_cnt;
    logic [63:0] deadline;
    int          err_count;
    t_decision   decision_q[$];

    function automatic int clamp_s8(input int v);
        if (v > 127) return 127;
        if (v < -128) return -128;
        return v;
    endfunction

    // Update counters and deadline for one tick and return the decision it yields.
    function automatic t_decision advance_decision(input t_tick t);
        t_decision   d;
        int          n;
        int          sum;
        int          avg;
        int          tgt;
        int          up_step;
        int          dn_step;
        int          up_lvl;
        int          dn_lvl;
        logic [63:0] now;
        logic [63:0] renewed;
        logic [63:0] half;
        d.action = ACT_NONE;
        d.core = 2'd0;
        now = 64'(t.now);
        n = int'(t.n);
        if (n < 1) n = 1;
        if (n > NUM_CORES) n = NUM_CORES;
        sum = 0;
        for (int i = 0; i < n; i++) sum += int'(t.load[i]);
        avg = sum / n;
        tgt = int'(count_target);

        if (t.gpu_quiet) begin
            up_step = int'(UP_IDLE);
            dn_step = int'(DN_IDLE);
        end else if (t.touch && n < int'(touch_cores)) begin
            up_step = int'(UP_TOUCH);
            dn_step = int'(DN_TOUCH);
        end else begin
            up_step = int'(UP_NORM);
            dn_step = int'(DN_NORM);
        end
        up_lvl = t.gpu_quiet ? int'(IDLE_UP[n-1]) : int'(BUSY_UP[n-1]);
        dn_lvl = t.gpu_quiet ? int'(IDLE_DN[n-1]) : int'(BUSY_DN[n-1]);
        renewed = (now + 64'(hold_ms)) & DEADLINE_MASK;

        if (avg >= up_lvl) begin
            deadline = renewed;
            if (up_cnt < tgt) up_cnt = clamp_s8(up_cnt + up_step);
            if (dn_cnt > 0) dn_cnt = clamp_s8(dn_cnt - up_step);
            // with every core online no core is brought up; the counters keep their updated values
            if (up_cnt >= tgt && n < NUM_CORES) begin
                d.action = ACT_UP;
                d.core = 2'(n);
                up_cnt = 0;
                dn_cnt = clamp_s8(-tgt);
            end
        end else if (avg <= dn_lvl) begin
            if (dn_cnt < tgt) dn_cnt = clamp_s8(dn_cnt + dn_step);
            if (up_cnt > 0) up_cnt = clamp_s8(up_cnt - dn_step);
            // never drop the last core, nor drop from the touch count before the deadline
            if (dn_cnt >= tgt && n != 1 && !(n == int'(touch_cores) && deadline > now)) begin
                d.action = ACT_DOWN;
                d.core = 2'(n - 1);
                deadline = renewed;
                up_cnt = 0;
                dn_cnt = 0;
            end
        end else begin
            half = now + 64'(hold_ms >> 1);
            if (half > deadline) deadline = half & DEADLINE_MASK;
            if (up_cnt > 0) up_cnt = clamp_s8(up_cnt - dn_step);
            if (dn_cnt > 0) dn_cnt = clamp_s8(dn_cnt - dn_step);
        end
        d.avg = LOAD_W'(avg);
        return d;
    endfunction

    always @(posedge i_clk) begin
        t_tick     req;
        t_decision want;
        if (!i_rst_n) begin
            touch_cores = RST_TOUCH_CORES;
            hold_ms = RST_HOLD_MS;
            count_target = RST_TARGET;
            up_cnt = 0;
            dn_cnt = 0;
            deadline = 64'd0;
            err_count = 0;
            decision_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TOUCH_CORES: touch_cores = i_cfg_data[2:0];
                    CFG_HOLD_MS:     hold_ms = i_cfg_data;
                    CFG_TARGET:      count_target = i_cfg_data[6:0];
                    default: ;
                endcase
            end

            // retire before predicting so a result never matches its own cycle's request
            if (i_res_valid && !i_res_stall) begin
                if (decision_q.size() == 0) begin
                    $display("%0t: result with nothing expected: action %0d core %0d avg %0d",
                             $time, i_action, i_target_core, i_average_load);
                    err_count++;
                end else begin
                    want = decision_q.pop_front();
                    if (i_action !== want.action) begin
                        $display("%0t: action expected %0d, got %0d",
                                 $time, want.action, i_action);
                        err_count++;
                    end
                    if (i_target_core !== want.core) begin
                        $display("%0t: target_core expected %0d, got %0d",
                                 $time, want.core, i_target_core);
                        err_count++;
                    end
                    if (i_average_load !== want.avg) begin
                        $display("%0t: average_load expected %0d, got %0d",
                                 $time, want.avg, i_average_load);
                        err_count++;
                    end
                end
            end

            if (i_req_valid && !i_req_stall) begin
                req.now = i_now_ms;
                req.load[0] = i_load_core0;
                req.load[1] = i_load_core1;
                req.load[2] = i_load_core2;
                req.load[3] = i_load_core3;
                req.n = i_cores_online;
                req.gpu_quiet = i_gpu_is_idle;
                req.touch = i_touch_boost_active;
                decision_q.push_back(advance_decision(req));
            end
        end
        o_pending <= decision_q.size();
        o_errors <= err_count;
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Top of the core_hotplug_decision testbench: clock, reset, request and result
// traffic, register settings per phase, watchdog and verdict.
// Depends on hpd_pkg, hpd_decision_checker and the block itself.
module testbench;
    import hpd_pkg::*;

    localparam int LONG_HOLD      = 160;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [NOW_W-1:0] NOW_MAX = '1;

    typedef enum int {
        LOAD_HIGH,
        LOAD_LOW,
        LOAD_MID,
        LOAD_NOISE
    } t_load_kind;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [NOW_W-1:0]      now_ms = '0;
    logic [LOAD_W-1:0]     load0 = '0;
    logic [LOAD_W-1:0]     load1 = '0;
    logic [LOAD_W-1:0]     load2 = '0;
    logic [LOAD_W-1:0]     load3 = '0;
    logic [N_W-1:0]        cores = 3'd1;
    logic                  gpu_quiet = 1'b0;
    logic                  touch = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [1:0]            action;
    logic [1:0]            target_core;
    logic [LOAD_W-1:0]     average_load;
    int                    errors;
    int                    pending;
    int                    quiet = 0;
    logic [NOW_W-1:0]      clock_ms = '0;
    bit                    tx_idle_on = 1'b1;

    core_hotplug_decision #(
        .NUM_CORES(NUM_CORES_DEF)
    ) i_dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_cfg_we             (cfg_we),
        .i_cfg_idx            (cfg_idx),
        .i_cfg_data           (cfg_data),
        .i_in_valid           (in_valid),
        .o_in_stall           (in_stall),
        .i_now_ms             (now_ms),
        .i_load_core0         (load0),
        .i_load_core1         (load1),
        .i_load_core2         (load2),
        .i_load_core3         (load3),
        .i_cores_online       (cores),
        .i_gpu_is_idle        (gpu_quiet),
        .i_touch_boost_active (touch),
        .o_out_valid          (out_valid),
        .i_out_stall          (out_stall),
        .o_action             (action),
        .o_target_core        (target_core),
        .o_average_load       (average_load)
    );

    hpd_decision_checker #(
        .NUM_CORES(NUM_CORES_DEF)
    ) u_check (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_cfg_we             (cfg_we),
        .i_cfg_idx            (cfg_idx),
        .i_cfg_data           (cfg_data),
        .i_req_valid          (in_valid),
        .i_req_stall          (in_stall),
        .i_now_ms             (now_ms),
        .i_load_core0         (load0),
        .i_load_core1         (load1),
        .i_load_core2         (load2),
        .i_load_core3         (load3),
        .i_cores_online       (cores),
        .i_gpu_is_idle        (gpu_quiet),
        .i_touch_boost_active (touch),
        .i_res_valid          (out_valid),
        .i_res_stall          (out_stall),
        .i_action             (action),
        .i_target_core        (target_core),
        .i_average_load       (average_load),
        .o_errors             (errors),
        .o_pending            (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one request and hold it until accepted, then maybe idle a little.
    task automatic send_tick(input logic [NOW_W-1:0] t, input logic [LOAD_W-1:0] l0,
                             input logic [LOAD_W-1:0] l1, input logic [LOAD_W-1:0] l2,
                             input logic [LOAD_W-1:0] l3, input logic [N_W-1:0] n,
                             input logic idle, input logic boost);
        int gap;
        now_ms <= t;
        load0 <= l0;
        load1 <= l1;
        load2 <= l2;
        load3 <= l3;
        cores <= n;
        gpu_quiet <= idle;
        touch <= boost;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        gap = tx_idle_on ? $urandom_range(0, 3) : 0;
        if ($urandom_range(0, 47) == 0) tx_idle_on = !tx_idle_on;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every decision is back and the pipe is quiet.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_regs(input logic [2:0] touch_cores, input logic [15:0] hold,
                            input logic [6:0] tgt);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_TOUCH_CORES;
        cfg_data <= {13'($urandom), touch_cores};
        @(posedge clk);
        cfg_idx <= CFG_HOLD_MS;
        cfg_data <= hold;
        @(posedge clk);
        cfg_idx <= CFG_TARGET;
        cfg_data <= {9'($urandom), tgt};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Advance the time base by about one decision period, sometimes by a big jump or not at all.
    task automatic step_clock;
        logic [63:0] ahead;
        ahead = 64'(clock_ms) + 64'($urandom_range(20, 40));
        if ($urandom_range(0, 63) == 0) ahead = ahead + ({$urandom, $urandom} >> 22);
        if ($urandom_range(0, 31) == 0) ahead = 64'(clock_ms);
        if (ahead <= 64'(NOW_MAX)) clock_ms = ahead[NOW_W-1:0];
    endtask

    function automatic logic [LOAD_W-1:0] draw_load(input t_load_kind kind);
        case (kind)
            LOAD_HIGH: begin
                if ($urandom_range(0, 3) == 0) return 7'($urandom_range(90, 127));
                return 7'($urandom_range(55, 100));
            end
            LOAD_LOW: begin
                if ($urandom_range(0, 3) == 0) return 7'd0;
                return 7'($urandom_range(0, 35));
            end
            LOAD_MID: return 7'($urandom_range(25, 75));
            default:  return 7'($urandom_range(0, 127));
        endcase
    endfunction

    // Runs of like-loaded ticks so the counters climb to their targets.
    task automatic run_bursts(input int count);
        int             left;
        int             run;
        int             pick;
        t_load_kind     kind;
        logic [N_W-1:0] n;
        logic           idle;
        logic           boost;
        left = count;
        while (left > 0) begin
            run = $urandom_range(3, 40);
            if (run > left) run = left;
            pick = $urandom_range(0, 9);
            if (pick < 4) kind = LOAD_HIGH;
            else if (pick < 7) kind = LOAD_LOW;
            else if (pick < 9) kind = LOAD_MID;
            else kind = LOAD_NOISE;
            if ($urandom_range(0, 6) == 0) begin
                n = 3'($urandom_range(4, 7));
                if (n == 3'd4) n = 3'd0;
            end else begin
                n = 3'($urandom_range(1, NUM_CORES_DEF));
            end
            idle = 1'($urandom_range(0, 1));
            boost = 1'($urandom_range(0, 1));
            repeat (run) begin
                step_clock();
                if ($urandom_range(0, 19) == 0) idle = !idle;
                if ($urandom_range(0, 19) == 0) boost = !boost;
                send_tick(clock_ms, draw_load(kind), draw_load(kind), draw_load(kind),
                          draw_load(kind), n, idle, boost);
            end
            left -= run;
        end
    endtask

    // Result side: random stalls, stretches without any, and two long hold-offs.
    initial begin
        int w;
        int got;
        bit idle_on;
        got = 0;
        idle_on = 1'b1;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (got == 300 || got == 1100) w = LONG_HOLD;
            else w = idle_on ? $urandom_range(0, 3) : 0;
            if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
            if (w > 0) begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            got++;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet == WATCHDOG_LIMIT) begin
            $display("core_hotplug_decision: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset register values: one core, all cores online, core count out of range
        send_tick(48'd0,   7'd0,   7'd0,   7'd0,   7'd0,   3'd1, 1'b1, 1'b0);
        send_tick(48'd30,  7'd127, 7'd127, 7'd127, 7'd127, 3'd4, 1'b0, 1'b0);
        send_tick(48'd60,  7'd100, 7'd127, 7'd127, 7'd127, 3'd0, 1'b0, 1'b0);
        send_tick(48'd90,  7'd0,   7'd127, 7'd0,   7'd127, 3'd7, 1'b1, 1'b1);
        send_tick(48'd120, 7'd101, 7'd102, 7'd103, 7'd104, 3'd5, 1'b0, 1'b1);
        send_tick(48'd150, 7'd50,  7'd50,  7'd50,  7'd0,   3'd3, 1'b0, 1'b0);
        // touch boost below the touch count: big up steps, bring core 1 up
        send_tick(48'd180, 7'd90,  7'd0,   7'd0,   7'd0,   3'd1, 1'b0, 1'b1);
        send_tick(48'd210, 7'd90,  7'd0,   7'd0,   7'd0,   3'd1, 1'b0, 1'b1);
        send_tick(48'd240, 7'd90,  7'd0,   7'd0,   7'd0,   3'd1, 1'b0, 1'b1);
        send_tick(48'd270, 7'd90,  7'd0,   7'd0,   7'd0,   3'd1, 1'b0, 1'b1);
        // low load at the touch count while the hold deadline is pending
        send_tick(48'd300, 7'd10,  7'd10,  7'd0,   7'd0,   3'd2, 1'b1, 1'b0);
        send_tick(48'd330, 7'd10,  7'd10,  7'd0,   7'd0,   3'd2, 1'b1, 1'b0);
        send_tick(48'd360, 7'd0,   7'd0,   7'd0,   7'd0,   3'd2, 1'b1, 1'b0);
        send_tick(48'd390, 7'd45,  7'd45,  7'd45,  7'd0,   3'd3, 1'b1, 1'b1);
        // deadline beyond the time field
        send_tick(NOW_MAX, 7'd127, 7'd127, 7'd0,   7'd0,   3'd2, 1'b0, 1'b0);
        send_tick(NOW_MAX, 7'd40,  7'd40,  7'd40,  7'd40,  3'd4, 1'b1, 1'b1);
        clock_ms = 48'd500;
        run_bursts(250);
        drain();

        set_regs(3'd1, 16'd0, 7'd1);
        clock_ms = NOW_W'({$urandom, $urandom});
        run_bursts(200);
        drain();

        set_regs(3'd4, 16'hFFFF, 7'd100);
        clock_ms = NOW_MAX - 48'd500000;
        run_bursts(250);
        drain();

        // zero count target: counters fire as soon as they are non-negative
        set_regs(3'd3, 16'($urandom), 7'd0);
        clock_ms = 48'd0;
        run_bursts(150);
        drain();

        repeat (3) begin
            set_regs(3'($urandom_range(1, 4)), 16'($urandom), 7'($urandom_range(1, 100)));
            clock_ms = NOW_W'({$urandom, $urandom} >> 17);
            run_bursts(230);
            drain();
        end

        if (errors == 0 && pending == 0) begin
            $display("core_hotplug_decision: match");
        end else begin
            $display("core_hotplug_decision: mismatch");
        end
        $finish;
    end

endmodule

>>> core_hotplug_decision.f
design/hpd_pkg.sv
design/hpd_lane.sv
design/hpd_merge.sv
design/hpd_ctrl.sv
design/core_hotplug_decision.sv
design/hpd_checker.sv
tb/hpd_decision_checker.sv
tb/testbench.sv
